// File: hdl/stick_channel_scaler_defines.svh
// Assertion macros for the stick channel scaler.
// Included by the top level, which checks its own sequencing; no other dependencies.
`ifndef STICK_CHANNEL_SCALER_DEFINES_SVH
`define STICK_CHANNEL_SCALER_DEFINES_SVH

`ifndef SYNTH
`define SCS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SCS_ASSERT_IMPLY(label, ante, cons, msg)
`define SCS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hdl/scs_pkg.sv
// Types, codes and fixed widths shared by the stick channel scaler.
// No dependencies; compiled before the interfaces and modules.
package scs_pkg;

   localparam int CHANNEL_W  = 3;
   localparam int SAMPLE_W   = 10;
   localparam int FUNC_W     = 2;
   localparam int WIDTH_W    = 12;
   localparam int PULSE_W    = 16;
   localparam int CAL_W      = 11;
   localparam int TRIM_W     = 8;
   localparam int DIVIDEND_W = 22;
   localparam int DIVISOR_W  = 10;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAL_W-1:0]   LOWER_RESET = 11'd1024;
   localparam logic [WIDTH_W-1:0] MIN_RESET   = 12'd700;
   localparam logic [WIDTH_W-1:0] MAX_RESET   = 12'd1700;

   typedef logic [FUNC_W-1:0]    func_type;
   typedef logic [CHANNEL_W-1:0] channel_type;
   typedef logic [SAMPLE_W-1:0]  sample_type;
   typedef logic [PULSE_W-1:0]   pulse_type;

   localparam func_type FUNC_SAMPLE    = 2'd0;
   localparam func_type FUNC_TRIM_UP   = 2'd1;
   localparam func_type FUNC_TRIM_DOWN = 2'd2;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_MIN_WIDTH = 2'd0;
   localparam reg_index_type REG_MAX_WIDTH = 2'd1;
   localparam reg_index_type REG_CAL_MODE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_ABS,
      ST_DIV,
      ST_ADJ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_sts_type;

endpackage

// File: hdl/scs_req_if.sv
// Input channel of the stick channel scaler: one sample or trim key per transaction.
// Depends on scs_pkg for the payload types.
interface scs_req_if;
   import scs_pkg::*;

   logic        valid;
   logic        ready;
   func_type    func;
   channel_type channel;
   sample_type  sample;

   modport source (output valid, output func, output channel, output sample, input ready);
   modport sink (input valid, input func, input channel, input sample, output ready);
endinterface

// File: hdl/scs_rsp_if.sv
// Result channel of the stick channel scaler: one pulse width per transaction.
// Depends on scs_pkg for the payload types.
interface scs_rsp_if;
   import scs_pkg::*;

   logic        valid;
   logic        ready;
   channel_type out_channel;
   pulse_type   pulse_width_us;
   logic        range_error;

   modport source (output valid, output out_channel, output pulse_width_us,
                   output range_error, input ready);
   modport sink (input valid, input out_channel, input pulse_width_us,
                 input range_error, output ready);
endinterface

// File: hdl/scs_divider.sv
// Restoring unsigned divider, one quotient bit per clock.
// Depends on scs_pkg for the control and status structs.
module scs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  scs_pkg::div_ctl_type ctl,
   output scs_pkg::div_sts_type sts
);
   import scs_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  den_ff;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic                  last;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};
   assign last    = cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (ctl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start && !busy_ff) begin
         quo_ff <= ctl.dividend;
         rem_ff <= '0;
         den_ff <= ctl.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      end
   end

   assign sts = '{busy: busy_ff, done: done_ff, quotient: quo_ff, remainder: rem_ff};

endmodule

// File: hdl/stick_channel_scaler.sv
// Top level of the stick channel scaler: channel state, sequencer and register port.
// Depends on scs_pkg, scs_req_if, scs_rsp_if, scs_divider and the assertion macros.
//
// Each transaction carries an ADC sample or a trim key for one channel. Trim keys,
// calibration samples and items for channels beyond NUM_CHANNELS give no result. A
// sample outside calibrate mode is mapped to a pulse width with one multiply and a
// bit-serial divide of the 22-bit product magnitude: the divider's 22 steps set the
// pace, and the next transaction is taken only once the result is in the output
// register. With an empty calibration range the divide is skipped. The result sits
// in an output register, so a new transaction can start while it waits to be taken.
`include "stick_channel_scaler_defines.svh"

module stick_channel_scaler #(
   parameter int NUM_CHANNELS = 8,
   parameter int TRIM_MAX     = 100,
   parameter int TRIM_MIN     = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   scs_req_if.sink                        req,
   scs_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [scs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [scs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import scs_pkg::*;

   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [TRIM_W-1:0] TRIM_HI = TRIM_W'(TRIM_MAX);
   localparam logic [TRIM_W-1:0] TRIM_LO = TRIM_W'(TRIM_MIN);

   // Register port.
   logic [WIDTH_W-1:0] min_width_ff;
   logic [WIDTH_W-1:0] max_width_ff;
   logic               cal_mode_ff;
   reg_index_type      csr_index;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_RESET;
         max_width_ff <= MAX_RESET;
         cal_mode_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_WIDTH: min_width_ff <= csr_pwdata[WIDTH_W-1:0];
            REG_MAX_WIDTH: max_width_ff <= csr_pwdata[WIDTH_W-1:0];
            REG_CAL_MODE:  cal_mode_ff  <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MIN_WIDTH: csr_prdata = CSR_DATA_W'(min_width_ff);
         REG_MAX_WIDTH: csr_prdata = CSR_DATA_W'(max_width_ff);
         REG_CAL_MODE:  csr_prdata = CSR_DATA_W'(cal_mode_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Sequencer.
   state_type   state_ff;
   state_type   state_in;
   logic        accept;
   logic        ch_ok;
   logic        rsp_free;
   div_ctl_type div_ctl;
   div_sts_type div_sts;

   logic [CH_IDX_W-1:0] req_idx;
   logic [CH_IDX_W-1:0] idx_ff;
   channel_type         ch_ff;
   sample_type          smp_ff;

   logic [CAL_W-1:0]  upper_ff [NUM_CHANNELS];
   logic [CAL_W-1:0]  lower_ff [NUM_CHANNELS];
   logic [TRIM_W-1:0] trim_ff  [NUM_CHANNELS];

   assign req_idx  = CH_IDX_W'(req.channel);
   assign ch_ok    = 32'(req.channel) < NUM_CHANNELS;
   assign accept   = req.valid && req.ready;
   assign rsp_free = !rsp.valid || rsp.ready;

   logic [CAL_W-1:0]  up_rd;
   logic [CAL_W-1:0]  lo_rd;
   logic [TRIM_W-1:0] trim_rd;
   logic [CAL_W-1:0]  span;
   logic              empty_range;

   assign up_rd       = upper_ff[idx_ff];
   assign lo_rd       = lower_ff[idx_ff];
   assign trim_rd     = trim_ff[idx_ff];
   assign span        = up_rd - lo_rd;
   assign empty_range = up_rd <= lo_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (accept && ch_ok && req.func == FUNC_SAMPLE && !cal_mode_ff) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = empty_range ? ST_ADJ : ST_ABS;
         end
         ST_ABS: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Channel state: trim keys and calibration are applied when the transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            upper_ff[i] <= '0;
            lower_ff[i] <= LOWER_RESET;
            trim_ff[i]  <= '0;
         end
      end else if (accept && ch_ok) begin
         unique case (req.func)
            FUNC_TRIM_UP: begin
               if (trim_ff[req_idx] >= TRIM_HI) begin
                  trim_ff[req_idx] <= TRIM_HI;
               end else begin
                  trim_ff[req_idx] <= trim_ff[req_idx] + 1'b1;
               end
            end
            FUNC_TRIM_DOWN: begin
               if (trim_ff[req_idx] != '0) begin
                  if (trim_ff[req_idx] - 1'b1 <= TRIM_LO) begin
                     trim_ff[req_idx] <= TRIM_LO;
                  end else begin
                     trim_ff[req_idx] <= trim_ff[req_idx] - 1'b1;
                  end
               end
            end
            FUNC_SAMPLE: begin
               if (cal_mode_ff) begin
                  if (upper_ff[req_idx] < CAL_W'(req.sample)) begin
                     upper_ff[req_idx] <= CAL_W'(req.sample);
                  end
                  if (lower_ff[req_idx] > CAL_W'(req.sample)) begin
                     lower_ff[req_idx] <= CAL_W'(req.sample);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath.
   logic signed [CAL_W:0]       diff;
   logic signed [WIDTH_W:0]     trav;
   logic signed [24:0]          prod_ff;
   logic [24:0]                 prod_mag;
   logic [DIVISOR_W-1:0]        den_ff;
   logic [WIDTH_W:0]            base_ff;
   logic                        err_ff;
   logic                        neg_ff;
   logic signed [23:0]          step_ff;
   logic signed [24:0]          sum;
   logic [PULSE_W-1:0]          width_ff;
   logic [DIVIDEND_W+1:0]       quo_ext;

   assign diff     = $signed({2'b00, smp_ff}) - $signed({1'b0, lo_rd});
   assign trav     = $signed({1'b0, max_width_ff}) - $signed({1'b0, min_width_ff});
   assign prod_mag = prod_ff[24] ? 25'(-prod_ff) : 25'(prod_ff);
   assign quo_ext  = {2'b00, div_sts.quotient};
   assign sum      = $signed({12'b0, base_ff}) + $signed({step_ff[23], step_ff});

   assign div_ctl = '{start: state_ff == ST_ABS, dividend: prod_mag[DIVIDEND_W-1:0],
                      divisor: den_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff <= req_idx;
         ch_ff  <= req.channel;
         smp_ff <= req.sample;
      end
      unique case (state_ff)
         ST_MULT: begin
            prod_ff <= diff * trav;
            den_ff  <= span[DIVISOR_W-1:0];
            err_ff  <= empty_range;
            base_ff <= {1'b0, min_width_ff} + (WIDTH_W + 1)'(trim_rd);
            step_ff <= '0;
         end
         ST_ABS: begin
            neg_ff <= prod_ff[24];
         end
         ST_DIV: begin
            if (div_sts.done) begin
               if (!neg_ff) begin
                  step_ff <= $signed(quo_ext);
               end else if (div_sts.remainder != '0) begin
                  step_ff <= $signed(~quo_ext);
               end else begin
                  step_ff <= $signed(-quo_ext);
               end
            end
         end
         ST_ADJ: begin
            if (sum < 0) begin
               width_ff <= '0;
            end else if (sum > 25'sd65535) begin
               width_ff <= '1;
            end else begin
               width_ff <= sum[PULSE_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   scs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   // Output register.
   logic        rsp_valid_ff;
   channel_type rsp_ch_ff;
   pulse_type   rsp_width_ff;
   logic        rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_ch_ff    <= ch_ff;
         rsp_width_ff <= width_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_channel    = rsp_ch_ff;
   assign rsp.pulse_width_us = rsp_width_ff;
   assign rsp.range_error    = rsp_err_ff;

   `SCS_ASSERT_IMPLY(a_start_when_free, div_ctl.start, !div_sts.busy, "divider started while busy")
   `SCS_ASSERT_IMPLY(a_done_in_div, div_sts.done, state_ff == ST_DIV, "divider done outside divide")
   `SCS_ASSERT_IMPLY(a_accept_div_idle, accept, !div_sts.busy, "transaction taken during divide")
   `SCS_ASSERT_NEXT(a_result_loaded, state_ff == ST_FINISH && rsp_free, rsp_valid_ff,
      "result not presented after finish")

endmodule
